>>> sv/bcd_pkg.sv
// Shared types, constants and chord decoding functions for the button chord detector.
// Used by every module of the block; depends on nothing else.
package bcd_pkg;

	// Fixed sizes of the pad and the chord table.
	localparam int NUM_BUTTONS     = 16;
	localparam int NUM_CHORDS      = 8;
	localparam int CODES_PER_CHORD = 4;
	localparam int CNT_W           = 4;
	localparam logic [CNT_W-1:0] REPEAT_DELAY = 4'd8;

	// A button code of six terminates a chord's code list.
	localparam logic [3:0] CODE_END = 4'd6;

	// Configuration register indexes and reset values.
	localparam int ADDR_W = 6;
	localparam logic [2:0] REG_RESERVED_MASK = 3'd0;
	localparam logic [2:0] REG_BIND_LO       = 3'd1;
	localparam logic [2:0] REG_BIND_HI       = 3'd2;
	localparam logic [2:0] REG_EXEMPT_INDEX  = 3'd3;
	localparam logic [2:0] REG_INPUT_ENABLE  = 3'd4;
	localparam logic [63:0] TABLE_RESET = 64'h6666_6666_6666_6666;

	typedef struct packed {
		logic [15:0] reserved_mask;
		logic [63:0] bind_table_lo;
		logic [63:0] bind_table_hi;
		logic [2:0]  exempt_index;
		logic        input_enable;
	} cfg_t;

	// Press and release edges of the current sample.
	typedef struct packed {
		logic [NUM_BUTTONS-1:0] rise;
		logic [NUM_BUTTONS-1:0] fall;
	} pad_edges_t;

	typedef struct packed {
		logic [CODES_PER_CHORD-1:0] progress;
		logic                       active;
	} walk_t;

	// Button set of a chord: codes up to the first end code.
	function automatic logic [NUM_BUTTONS-1:0] chord_mask(input logic [15:0] word);
		logic [NUM_BUTTONS-1:0] m;
		logic                   done;
		logic [3:0]             c;
		m    = '0;
		done = 1'b0;
		for (int j = 0; j < CODES_PER_CHORD; j++) begin
			c = word[4*j +: 4];
			if (!done) begin
				if (c == CODE_END) begin
					done = 1'b1;
				end else begin
					m[c] = 1'b1;
				end
			end
		end
		return m;
	endfunction

	// Walk a chord's components in order and work out its new progress bits.
	// The chord is complete when the walk passes every listed component.
	function automatic walk_t chord_walk(
		input logic [15:0]                  word,
		input logic [CODES_PER_CHORD-1:0]   prog,
		input logic [NUM_BUTTONS-1:0]       pad,
		input pad_edges_t                   edges,
		input logic [NUM_BUTTONS-1:0]       mask
	);
		walk_t                      r;
		logic [CODES_PER_CHORD-1:0] cs;
		logic                       done;
		logic                       complete;
		logic                       stray;
		logic [3:0]                 c;
		cs       = prog;
		done     = 1'b0;
		complete = 1'b0;
		stray    = (prog != '0) && ((edges.rise & ~mask) != '0);
		for (int j = 0; j < CODES_PER_CHORD; j++) begin
			c = word[4*j +: 4];
			if (!done) begin
				if (c == CODE_END) begin
					done     = 1'b1;
					complete = 1'b1;
				end else if (cs[j]) begin
					// Component already down: a release cancels it, and cancels
					// the whole chord when later components are down too.
					if (!pad[c]) begin
						if ((cs >> (j + 1)) != '0) begin
							cs = '0;
						end else begin
							cs[j] = 1'b0;
						end
						done = 1'b1;
					end
				end else if (edges.fall[c] || stray) begin
					cs   = '0;
					done = 1'b1;
				end else if (edges.rise[c]) begin
					cs[j] = 1'b1;
				end else begin
					done = 1'b1;
				end
			end
		end
		if (!done) begin
			complete = 1'b1;
		end
		r.progress = cs;
		r.active   = (cs != '0) && complete;
		return r;
	endfunction

endpackage

>>> sv/bcd_cfg_regs.sv
// Configuration register file with its APB-style access port.
// Depends on bcd_pkg for the register indexes, reset values and cfg_t.
module bcd_cfg_regs
	import bcd_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [63:0]       pwdata,
	output logic [63:0]       prdata,
	output logic              pready,
	output cfg_t              cfg
);

	logic       wr_en;
	logic [2:0] reg_idx;
	cfg_t       cfg_q;

	assign pready  = 1'b1;
	assign reg_idx = paddr[ADDR_W-1:3];
	assign wr_en   = psel & penable & pwrite & pready;
	assign cfg     = cfg_q;

	// Register writes; an index beyond the list is ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.reserved_mask <= '0;
			cfg_q.bind_table_lo <= TABLE_RESET;
			cfg_q.bind_table_hi <= TABLE_RESET;
			cfg_q.exempt_index  <= '0;
			cfg_q.input_enable  <= 1'b1;
		end else if (wr_en) begin
			case (reg_idx)
				REG_RESERVED_MASK: cfg_q.reserved_mask <= pwdata[15:0];
				REG_BIND_LO:       cfg_q.bind_table_lo <= pwdata;
				REG_BIND_HI:       cfg_q.bind_table_hi <= pwdata;
				REG_EXEMPT_INDEX:  cfg_q.exempt_index  <= pwdata[2:0];
				REG_INPUT_ENABLE:  cfg_q.input_enable  <= pwdata[0];
				default: begin
				end
			endcase
		end
	end

	// Read-back multiplexer.
	always_comb begin
		case (reg_idx)
			REG_RESERVED_MASK: prdata = {48'd0, cfg_q.reserved_mask};
			REG_BIND_LO:       prdata = cfg_q.bind_table_lo;
			REG_BIND_HI:       prdata = cfg_q.bind_table_hi;
			REG_EXEMPT_INDEX:  prdata = {61'd0, cfg_q.exempt_index};
			REG_INPUT_ENABLE:  prdata = {63'd0, cfg_q.input_enable};
			default:           prdata = '0;
		endcase
	end

endmodule

>>> sv/bcd_button_unit.sv
// Per-button edge detection and auto-repeat hold counters.
// Depends on bcd_pkg for sizes, the repeat threshold and pad_edges_t.
module bcd_button_unit
	import bcd_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   advance,
	input  logic [NUM_BUTTONS-1:0] pad,
	output pad_edges_t             edges,
	output logic [NUM_BUTTONS-1:0] press
);

	logic [NUM_BUTTONS-1:0] prev_pad_q;
	logic [CNT_W-1:0]       hold_q   [NUM_BUTTONS];
	logic [CNT_W-1:0]       hold_nxt [NUM_BUTTONS];
	logic [NUM_BUTTONS-1:0] changed;

	assign changed    = prev_pad_q ^ pad;
	assign edges.rise = changed & pad;
	assign edges.fall = changed & ~pad;

	// Saturating hold count per button; a press or a long hold sets its bit.
	always_comb begin
		for (int i = 0; i < NUM_BUTTONS; i++) begin
			if (!pad[i]) begin
				hold_nxt[i] = '0;
			end else if (hold_q[i] < REPEAT_DELAY) begin
				hold_nxt[i] = hold_q[i] + 1'b1;
			end else begin
				hold_nxt[i] = hold_q[i];
			end
			press[i] = edges.rise[i] || (hold_nxt[i] >= REPEAT_DELAY);
		end
	end

	// State moves on only when a beat is processed.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_pad_q <= '0;
			for (int i = 0; i < NUM_BUTTONS; i++) begin
				hold_q[i] <= '0;
			end
		end else if (advance) begin
			prev_pad_q <= pad;
			for (int i = 0; i < NUM_BUTTONS; i++) begin
				hold_q[i] <= hold_nxt[i];
			end
		end
	end

endmodule

>>> sv/bcd_chord_unit.sv
// Chord tracking: ordered component walk, subset suppression and hold counters.
// Depends on bcd_pkg for cfg_t, pad_edges_t and the chord decoding functions.
module bcd_chord_unit
	import bcd_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   advance,
	input  cfg_t                   cfg,
	input  logic [NUM_BUTTONS-1:0] pad,
	input  pad_edges_t             edges,
	output logic [NUM_CHORDS-1:0]  chord_held,
	output logic [NUM_CHORDS-1:0]  chord_pressed,
	output logic [NUM_CHORDS-1:0]  chord_edge
);

	logic [CODES_PER_CHORD-1:0] prog_q   [NUM_CHORDS];
	logic [CODES_PER_CHORD-1:0] prog_nxt [NUM_CHORDS];
	logic [CNT_W-1:0]           hold_q   [NUM_CHORDS];
	logic [CNT_W-1:0]           hold_nxt [NUM_CHORDS];
	logic [NUM_BUTTONS-1:0]     mask     [NUM_CHORDS];
	walk_t                      walk     [NUM_CHORDS];
	logic [NUM_CHORDS-1:0]      act;
	logic [NUM_CHORDS-1:0]      act_f;
	logic [127:0]               table_all;

	assign table_all = {cfg.bind_table_hi, cfg.bind_table_lo};

	// Component walk per chord, or a clear for reserved buttons or disabled input.
	always_comb begin
		for (int k = 0; k < NUM_CHORDS; k++) begin
			mask[k] = chord_mask(table_all[16*k +: 16]);
			if (((cfg.reserved_mask & mask[k]) != '0 && k != 0
					&& 3'(k) != cfg.exempt_index) || !cfg.input_enable) begin
				walk[k].progress = '0;
				walk[k].active   = 1'b0;
			end else begin
				walk[k] = chord_walk(table_all[16*k +: 16], prog_q[k], pad, edges, mask[k]);
			end
			act[k] = walk[k].active;
		end
	end

	// Subset suppression in index order: lower chords use their final flag.
	always_comb begin
		for (int k = 0; k < NUM_CHORDS; k++) begin
			act_f[k] = act[k];
			for (int j = 0; j < NUM_CHORDS; j++) begin
				if (act_f[k] && ((j < k) ? act_f[j] : act[j]) && mask[k] != mask[j]
						&& (mask[k] & mask[j]) == mask[k]) begin
					act_f[k] = 1'b0;
				end
			end
		end
	end

	// Hold counters and per-chord flags.
	always_comb begin
		for (int k = 0; k < NUM_CHORDS; k++) begin
			prog_nxt[k] = (act[k] && !act_f[k]) ? '0 : walk[k].progress;
			if (!act_f[k]) begin
				hold_nxt[k] = '0;
			end else if (hold_q[k] < REPEAT_DELAY) begin
				hold_nxt[k] = hold_q[k] + 1'b1;
			end else begin
				hold_nxt[k] = hold_q[k];
			end
			chord_edge[k]    = act_f[k] && (hold_q[k] == '0);
			chord_held[k]    = hold_nxt[k] != '0;
			chord_pressed[k] = chord_edge[k] || (hold_nxt[k] >= REPEAT_DELAY);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < NUM_CHORDS; k++) begin
				prog_q[k] <= '0;
				hold_q[k] <= '0;
			end
		end else if (advance) begin
			for (int k = 0; k < NUM_CHORDS; k++) begin
				prog_q[k] <= prog_nxt[k];
				hold_q[k] <= hold_nxt[k];
			end
		end
	end

endmodule

>>> sv/button_chord_detector.sv
// Top level of the button chord detector: input register, result register and units.
// Depends on bcd_pkg, bcd_cfg_regs, bcd_button_unit and bcd_chord_unit.
//
//   Channel   Direction  Payload
//   s_axis    in         tdata[31:0]: pad_sample, stick_horiz, stick_vert
//   m_axis    out        tdata[87:0]: pressed_repeat, held_levels, released_edges,
//                        chord_held, chord_pressed, chord_edge, stick_horiz_out, stick_vert_out
//   apb       in/out     five registers at byte addresses 0, 8, 16, 24, 32
//
// Each poll beat is registered on entry, evaluated by combinational
// logic against the button and chord state, and its result registered for output.
// One beat is taken every cycle unless the output stalls with both registers full.
// The input stage keeps accepting while a result waits, until both registers are full.
// Reset clears all hold counters, chord progress and the previous pad sample.
module button_chord_detector
	import bcd_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_axis_tvalid,
	output logic              s_axis_tready,
	input  logic [31:0]       s_axis_tdata,   // pad_sample, stick_horiz, stick_vert
	output logic              m_axis_tvalid,
	input  logic              m_axis_tready,
	output logic [87:0]       m_axis_tdata,   // pressed_repeat, held_levels, released_edges,
	                                          // chord_held, chord_pressed, chord_edge,
	                                          // stick_horiz_out, stick_vert_out
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [63:0]       pwdata,
	output logic [63:0]       prdata,
	output logic              pready
);

	cfg_t                   cfg;
	pad_edges_t             edges;
	logic [NUM_BUTTONS-1:0] press;
	logic [NUM_CHORDS-1:0]  c_held;
	logic [NUM_CHORDS-1:0]  c_pressed;
	logic [NUM_CHORDS-1:0]  c_edge;
	logic                   advance;

	logic                   valid_s1;
	logic [15:0]            pad_s1;
	logic signed [7:0]      sx_s1;
	logic signed [7:0]      sy_s1;
	logic                   valid_s2;
	logic [87:0]            data_s2;

	// A beat in the input register moves on when the result register is free.
	assign advance       = valid_s1 && (!valid_s2 || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;
	assign m_axis_tvalid = valid_s2;
	assign m_axis_tdata  = data_s2;

	bcd_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	bcd_button_unit u_buttons (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.pad     (pad_s1),
		.edges   (edges),
		.press   (press)
	);

	bcd_chord_unit u_chords (
		.clk           (clk),
		.arst_n        (arst_n),
		.advance       (advance),
		.cfg           (cfg),
		.pad           (pad_s1),
		.edges         (edges),
		.chord_held    (c_held),
		.chord_pressed (c_pressed),
		.chord_edge    (c_edge)
	);

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			pad_s1 <= s_axis_tdata[15:0];
			sx_s1  <= s_axis_tdata[23:16];
			sy_s1  <= s_axis_tdata[31:24];
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (m_axis_tready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			data_s2 <= {sy_s1, sx_s1, c_edge, c_pressed, c_held, edges.fall, pad_s1,
				cfg.input_enable ? press : 16'd0};
		end
	end

endmodule

>>> tb/tb_button_chord_detector.sv
// Self-checking testbench for the button chord detector: poll beats go in on the slave
// stream, results are compared field by field against an in-bench model of the block.
// Depends on bcd_pkg and button_chord_detector, and through it on the block's units.
module tb_button_chord_detector;
	import bcd_pkg::*;

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int PHASE_POLLS    = 160;
	localparam int LONG_STALL     = 60;
	localparam int NUM_PHASES     = 7;
	localparam int PRINT_CAP      = 40;
	localparam logic [2:0] REG_UNUSED_LO = 3'd5;
	localparam logic [2:0] REG_UNUSED_HI = 3'd7;

	// Result fields, last field in the lowest bits of tdata.
	typedef struct packed {
		logic [7:0]  stick_vert_out;
		logic [7:0]  stick_horiz_out;
		logic [7:0]  chord_edge;
		logic [7:0]  chord_pressed;
		logic [7:0]  chord_held;
		logic [15:0] released_edges;
		logic [15:0] held_levels;
		logic [15:0] pressed_repeat;
	} poll_result_t;

	logic              clk           = 1'b0;
	logic              arst_n        = 1'b0;
	logic              s_axis_tvalid = 1'b0;
	logic              s_axis_tready;
	logic [31:0]       s_axis_tdata  = '0;
	logic              m_axis_tvalid;
	logic              m_axis_tready = 1'b0;
	logic [87:0]       m_axis_tdata;
	logic              psel          = 1'b0;
	logic              penable       = 1'b0;
	logic              pwrite        = 1'b0;
	logic [ADDR_W-1:0] paddr         = '0;
	logic [63:0]       pwdata        = '0;
	logic [63:0]       prdata;
	logic              pready;

	button_chord_detector u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready)
	);

	always #5 clk = ~clk;

	// Register copies held by the bench, starting at their reset values.
	logic [15:0] cfg_reserved = '0;
	logic [63:0] cfg_bind_lo  = TABLE_RESET;
	logic [63:0] cfg_bind_hi  = TABLE_RESET;
	logic [2:0]  cfg_exempt   = '0;
	logic        cfg_enable   = 1'b1;

	// Button and chord state of the model.
	logic [15:0] last_pad = '0;
	logic [3:0]  button_hold[NUM_BUTTONS];
	logic [3:0]  chord_steps[NUM_CHORDS];
	logic [3:0]  chord_hold[NUM_CHORDS];

	initial begin
		foreach (button_hold[i]) button_hold[i] = '0;
		foreach (chord_steps[i]) chord_steps[i] = '0;
		foreach (chord_hold[i]) chord_hold[i] = '0;
	end

	logic [31:0]  poll_queue[$];
	poll_result_t expected_results[$];

	int   polls_queued    = 0;
	int   polls_accepted  = 0;
	int   results_checked = 0;
	int   mismatch_count  = 0;
	int   quiet_cycles    = 0;
	int   chord_edge_hits = 0;
	int   chord_rep_hits  = 0;
	int   phase_polls     = 0;
	int   send_gap        = 0;
	int   stall_left      = 0;
	logic long_stall_done = 1'b0;
	logic quiet_tail      = 1'b0;
	logic beat_taken      = 1'b0;
	logic [15:0] pad_level = '0;

	// Button set of one chord word: codes up to the first end code.
	function automatic logic [15:0] chord_buttons(input logic [15:0] word);
		logic [15:0] set;
		logic [3:0]  code;
		set = '0;
		for (int j = 0; j < CODES_PER_CHORD; j++) begin
			code = word[4*j +: 4];
			if (code == CODE_END) break;
			set[code] = 1'b1;
		end
		return set;
	endfunction

	// Advance the model by one poll and return the result it should give.
	function automatic poll_result_t predict_poll(input logic [15:0] pad,
			input logic [7:0] horiz, input logic [7:0] vert);
		poll_result_t r;
		logic [15:0]  rise, fall, press, word;
		logic [15:0]  sets[NUM_CHORDS];
		logic         active[NUM_CHORDS];
		logic [3:0]   cs, prior_cs, code;
		logic         first;
		int           j;
		rise  = (last_pad ^ pad) & pad;
		fall  = (last_pad ^ pad) & ~pad;
		press = '0;
		r     = '0;
		last_pad = pad;

		// Per-button hold counters saturate at the repeat delay.
		for (int i = 0; i < NUM_BUTTONS; i++) begin
			if (pad[i]) begin
				if (button_hold[i] < REPEAT_DELAY) button_hold[i] = button_hold[i] + 1'b1;
			end else begin
				button_hold[i] = '0;
			end
			if (rise[i] || button_hold[i] >= REPEAT_DELAY) press[i] = 1'b1;
		end

		// Walk each chord's components in order.
		for (int k = 0; k < NUM_CHORDS; k++) begin
			word    = (k < 4) ? cfg_bind_lo[16*k +: 16] : cfg_bind_hi[16*(k-4) +: 16];
			cs      = chord_steps[k];
			code    = CODE_END;
			j       = 0;
			sets[k] = chord_buttons(word);
			if (((cfg_reserved & sets[k]) != '0 && k != 0 && k != cfg_exempt) || !cfg_enable) begin
				cs = '0;
			end else begin
				prior_cs = cs;
				for (j = 0; j < CODES_PER_CHORD; j++) begin
					code = word[4*j +: 4];
					if (code == CODE_END) break;
					if (cs[j]) begin
						if (pad[code]) continue;
						// A released component drops the whole chord if later ones are down.
						if ((cs >> (j + 1)) != '0) cs = '0;
						else cs[j] = 1'b0;
						break;
					end
					if (fall[code] || (prior_cs != '0 && (rise & ~sets[k]) != '0)) begin
						cs = '0;
						break;
					end else if (rise[code]) begin
						cs[j] = 1'b1;
					end else begin
						break;
					end
				end
			end
			chord_steps[k] = cs;
			active[k]      = (cs != '0) && (j == CODES_PER_CHORD || code == CODE_END);
		end

		// Subset suppression, lowest index first, then the chord flags.
		for (int k = 0; k < NUM_CHORDS; k++) begin
			for (j = 0; active[k] && j < NUM_CHORDS; j++) begin
				if (!active[j]) continue;
				if (sets[k] != sets[j] && (sets[k] & sets[j]) == sets[k]) begin
					chord_steps[k] = '0;
					active[k]      = 1'b0;
				end
			end
			first = (chord_hold[k] == '0) && active[k];
			if (!active[k]) chord_hold[k] = '0;
			else if (chord_hold[k] < REPEAT_DELAY) chord_hold[k] = chord_hold[k] + 1'b1;
			if (chord_hold[k] != '0) r.chord_held[k] = 1'b1;
			if (first) r.chord_edge[k] = 1'b1;
			if (first || chord_hold[k] >= REPEAT_DELAY) r.chord_pressed[k] = 1'b1;
		end

		r.pressed_repeat  = cfg_enable ? press : '0;
		r.held_levels     = pad;
		r.released_edges  = fall;
		r.stick_horiz_out = horiz;
		r.stick_vert_out  = vert;
		return r;
	endfunction

	// Print is capped so a broken block cannot flood the log; every mismatch is counted.
	task automatic report_mismatch(input string msg);
		mismatch_count++;
		if (mismatch_count <= PRINT_CAP)
			$display("MISMATCH at result %0d: %s", results_checked, msg);
	endtask

	task automatic check_field(input string name, input logic [15:0] got,
			input logic [15:0] want);
		if (got !== want) report_mismatch($sformatf("%s got %h expected %h", name, got, want));
	endtask

	// Monitor: records accepted poll beats, predicts, and checks result beats.
	always @(posedge clk) begin : monitor
		poll_result_t got, want;
		logic         out_fire;
		if (arst_n) begin
			beat_taken = s_axis_tvalid && s_axis_tready;
			out_fire   = m_axis_tvalid && m_axis_tready;
			if (beat_taken) begin
				expected_results.push_back(predict_poll(s_axis_tdata[15:0],
					s_axis_tdata[23:16], s_axis_tdata[31:24]));
				polls_accepted++;
			end
			if (out_fire) begin
				got = m_axis_tdata;
				results_checked++;
				if (got.chord_edge != '0) chord_edge_hits++;
				if ((got.chord_pressed & ~got.chord_edge) != '0) chord_rep_hits++;
				if (expected_results.size() == 0) begin
					report_mismatch("result beat with no poll outstanding");
				end else begin
					want = expected_results.pop_front();
					check_field("pressed_repeat", got.pressed_repeat, want.pressed_repeat);
					check_field("held_levels", got.held_levels, want.held_levels);
					check_field("released_edges", got.released_edges, want.released_edges);
					check_field("chord_held", got.chord_held, want.chord_held);
					check_field("chord_pressed", got.chord_pressed, want.chord_pressed);
					check_field("chord_edge", got.chord_edge, want.chord_edge);
					check_field("stick_horiz_out", got.stick_horiz_out, want.stick_horiz_out);
					check_field("stick_vert_out", got.stick_vert_out, want.stick_vert_out);
				end
			end
			if (beat_taken || out_fire) quiet_cycles = 0;
			else quiet_cycles++;
		end
	end

	// Driver: presents queued polls, with short random gaps between beats.
	always @(negedge clk) begin
		if (arst_n && (!s_axis_tvalid || beat_taken)) begin
			if (send_gap == 0 && !quiet_tail && $urandom_range(0, 7) == 0)
				send_gap = $urandom_range(1, 4);
			if (send_gap > 0) begin
				send_gap--;
				s_axis_tvalid <= 1'b0;
			end else if (poll_queue.size() != 0) begin
				s_axis_tdata  <= poll_queue.pop_front();
				s_axis_tvalid <= 1'b1;
			end else begin
				s_axis_tvalid <= 1'b0;
			end
		end
	end

	// Receiver: random back-pressure bursts, plus one long hold-off to fill the block.
	always @(negedge clk) begin
		if (arst_n) begin
			if (!long_stall_done && results_checked >= 300) begin
				long_stall_done = 1'b1;
				stall_left      = LONG_STALL;
			end
			if (stall_left > 0) begin
				stall_left--;
				m_axis_tready <= 1'b0;
			end else if (!quiet_tail && $urandom_range(0, 7) == 0) begin
				stall_left = $urandom_range(0, 3);
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	// Watchdog: no beat moving on either side for too long ends the run.
	initial begin
		wait (quiet_cycles >= WATCHDOG_LIMIT);
		$display("Timeout: no beat moved for %0d cycles", WATCHDOG_LIMIT);
		$display("TEST FAILED");
		$finish;
	end

	// Register write: setup cycle, then access cycle; the model copy follows.
	task automatic apb_write(input logic [2:0] index, input logic [63:0] value);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {index, 3'b000};
		pwdata  <= value;
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		case (index)
			REG_RESERVED_MASK: cfg_reserved = value[15:0];
			REG_BIND_LO:       cfg_bind_lo  = value;
			REG_BIND_HI:       cfg_bind_hi  = value;
			REG_EXEMPT_INDEX:  cfg_exempt   = value[2:0];
			REG_INPUT_ENABLE:  cfg_enable   = value[0];
			default: ;
		endcase
	endtask

	task automatic apply_settings(input logic [15:0] reserved, input logic [63:0] lo,
			input logic [63:0] hi, input logic [2:0] exempt, input logic enable);
		apb_write(REG_RESERVED_MASK, {48'd0, reserved});
		apb_write(REG_BIND_LO, lo);
		apb_write(REG_BIND_HI, hi);
		apb_write(REG_EXEMPT_INDEX, {61'd0, exempt});
		apb_write(REG_INPUT_ENABLE, {63'd0, enable});
	endtask

	// Wait until every poll has been taken and every result checked.
	task automatic wait_drained();
		do @(negedge clk);
		while (polls_accepted != polls_queued || expected_results.size() != 0);
		repeat (3) @(negedge clk);
	endtask

	task automatic push_poll(input logic [15:0] pad);
		logic [7:0] horiz, vert;
		horiz = 8'($urandom);
		vert  = 8'($urandom);
		poll_queue.push_back({vert, horiz, pad});
		pad_level = pad;
		polls_queued++;
		phase_polls++;
	endtask

	// A chord word of 0 to 4 non-end codes; sometimes a prefix of the previous chord.
	function automatic logic [15:0] random_chord_word(input logic [15:0] prev, input logic chained);
		logic [15:0] word;
		logic [3:0]  code;
		int          count;
		word  = 16'($urandom);
		count = $urandom_range(0, CODES_PER_CHORD);
		for (int j = 0; j < CODES_PER_CHORD; j++) begin
			if (j < count) begin
				do code = 4'($urandom_range(0, 15));
				while (code == CODE_END);
				word[4*j +: 4] = code;
			end else if (j == count) begin
				word[4*j +: 4] = CODE_END;
			end
		end
		if (chained && $urandom_range(0, 2) == 0) begin
			word = prev;
			word[4*$urandom_range(1, 3) +: 4] = CODE_END;
		end
		return word;
	endfunction

	function automatic logic [63:0] random_bindings();
		logic [63:0] bank;
		logic [15:0] word;
		word = {4{CODE_END}};
		for (int k = 0; k < 4; k++) begin
			word = random_chord_word(word, k != 0);
			bank[16*k +: 16] = word;
		end
		return bank;
	endfunction

	// Press a chord's buttons in order, hold it with the odd stray change, then let go.
	task automatic queue_chord_run(input int k);
		logic [15:0] word, pad;
		logic [3:0]  code;
		int          flip;
		word = (k < 4) ? cfg_bind_lo[16*k +: 16] : cfg_bind_hi[16*(k-4) +: 16];
		pad  = ($urandom_range(0, 1) == 0) ? 16'h0000 : pad_level;
		if (pad != pad_level) push_poll(pad);
		for (int j = 0; j < CODES_PER_CHORD; j++) begin
			code = word[4*j +: 4];
			if (code == CODE_END) break;
			pad[code] = 1'b1;
			if (j == CODES_PER_CHORD - 1 || $urandom_range(0, 3) != 0) push_poll(pad);
		end
		repeat ($urandom_range(0, 11)) begin
			if ($urandom_range(0, 9) == 0) begin
				flip = $urandom_range(0, 15);
				pad[flip] = ~pad[flip];
			end
			push_poll(pad);
		end
		if ($urandom_range(0, 1) == 0) pad = '0;
		else pad = pad & 16'($urandom);
		push_poll(pad);
	endtask

	// Hold a single button long enough to reach auto-repeat.
	task automatic queue_button_hold();
		logic [15:0] pad;
		int          b;
		b      = $urandom_range(0, 15);
		pad    = pad_level;
		pad[b] = 1'b1;
		repeat ($urandom_range(8, 12)) push_poll(pad);
		pad[b] = 1'b0;
		push_poll(pad);
	endtask

	// Directed polls: extremes, ordered presses, repeat, stray press, early release,
	// pressing a chord and its superset together, a reserved chord and an exempt one.
	logic [15:0] directed_pads[25] = '{
		16'h0000, 16'hFFFF, 16'h0000, 16'h0002, 16'h0006,
		16'h0006, 16'h0006, 16'h0006, 16'h0006, 16'h0006,
		16'h0006, 16'h0006, 16'h0006, 16'h0406, 16'h0000,
		16'h000E, 16'h000A, 16'h0100, 16'h0300, 16'h0700,
		16'h0F00, 16'h0D00, 16'h0030, 16'h00B0, 16'h0001
	};

	initial begin : stimulus
		int pick;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Chord 0 {1,2}, 1 {1,2,3}, 2 empty, 3 {8,9,10,11}, 4 {0}, 5 {15..12},
		// 6 {4,5} exempt, 7 {7,4} blocked by the reserved button 4.
		apply_settings(16'h0010, 64'hBA98_6666_6321_6621, 64'h6647_6654_CDEF_6660, 3'd6, 1'b1);
		apb_write(REG_UNUSED_LO, '1);
		apb_write(REG_UNUSED_HI, 64'h0);
		poll_queue.push_back({8'h7F, 8'h80, directed_pads[0]});
		poll_queue.push_back({8'h80, 8'h7F, directed_pads[1]});
		polls_queued += 2;
		pad_level = directed_pads[1];
		for (int i = 2; i < 25; i++) push_poll(directed_pads[i]);
		wait_drained();

		// Random phases, each under its own register setting.
		for (int phase = 1; phase <= NUM_PHASES; phase++) begin
			case (phase)
				1: apply_settings(16'h0000, random_bindings(), random_bindings(), 3'd0, 1'b1);
				2: apply_settings(16'h0001 << $urandom_range(0, 15), random_bindings(),
					random_bindings(), 3'($urandom_range(0, 7)), 1'b1);
				3: apply_settings(16'hFFFF, random_bindings(), random_bindings(), 3'd7, 1'b1);
				4: apply_settings(16'h0000, 64'h0, '1, 3'($urandom_range(0, 7)), 1'b1);
				5: apply_settings(16'($urandom), random_bindings(), random_bindings(),
					3'($urandom_range(0, 7)), 1'b0);
				6: apply_settings(16'($urandom), {$urandom, $urandom}, {$urandom, $urandom},
					3'd3, 1'b1);
				default: apply_settings(16'h0001 << $urandom_range(0, 15), random_bindings(),
					random_bindings(), 3'($urandom_range(0, 7)), 1'b1);
			endcase
			if (phase == NUM_PHASES) quiet_tail = 1'b1;
			phase_polls = 0;
			while (phase_polls < PHASE_POLLS) begin
				pick = $urandom_range(0, 19);
				if (pick < 14) queue_chord_run($urandom_range(0, NUM_CHORDS - 1));
				else if (pick < 17) queue_button_hold();
				else repeat ($urandom_range(1, 3)) push_poll(16'($urandom));
			end
			wait_drained();
		end

		repeat (4) @(negedge clk);
		$display("Covered %0d polls over %0d register settings with back-pressure and gaps.",
			polls_accepted, NUM_PHASES + 1);
		$display("Results: %0d checked, %0d with a chord edge, %0d with a chord repeat, %0d bad.",
			results_checked, chord_edge_hits, chord_rep_hits, mismatch_count);
		if (mismatch_count == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule
